// ===== hw/rtl/stq_pkg.sv =====
// Shared types and constants for the slot table with mask query.
// Used by stq_ctrl, stq_dp and slot_table_with_mask_query; no dependencies.
`default_nettype none

package stq_pkg;

    // Table geometry
    localparam int MAX_SLOTS      = 64;
    localparam int COMPONENT_BITS = 32;

    // Fixed field widths of the stream beats
    localparam int SLOT_W      = 6;
    localparam int MASK_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Derived widths
    localparam int SIG_W  = (COMPONENT_BITS < MASK_W) ? COMPONENT_BITS : MASK_W;
    localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PTR_W  = $clog2(MAX_SLOTS + 1);

    // Free-slot search is split into groups of eight slots
    localparam int GRP_SIZE = 8;
    localparam int GRP_IW   = $clog2(GRP_SIZE);
    localparam int NUM_GRP  = (MAX_SLOTS + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE  = 2'd0,
        FN_DESTROY = 2'd1,
        FN_SET     = 2'd2,
        FN_QUERY   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CSUM,
        S_CPICK,
        S_QSCAN,
        S_QEND
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SUM,
        CMD_PICK,
        CMD_SCAN,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_ctrl.sv =====
// Sequencer for the slot table: walks create, query and simple updates.
// Depends on stq_pkg; drives commands into stq_dp and reads its status.
`default_nettype none

module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire t_func   i_func,
    input  wire t_dp_sts i_sts,
    output logic         o_s_tready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_func == FN_CREATE) begin
                        n_state = S_CSUM;
                    end else if (i_func == FN_QUERY) begin
                        n_state = S_QSCAN;
                    end
                end
            end
            S_CSUM: begin
                n_state = S_CPICK;
            end
            S_CPICK: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_QSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_QEND;
                end
            end
            S_QEND: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd = CMD_LOAD;
                end
            end
            S_CSUM: begin
                o_cmd = CMD_SUM;
            end
            S_CPICK: begin
                if (i_sts.out_free) begin
                    o_cmd = CMD_PICK;
                end
            end
            S_QSCAN: begin
                o_cmd = CMD_SCAN;
            end
            S_QEND: begin
                if (i_sts.out_free) begin
                    o_cmd = CMD_FINISH;
                end
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stq_dp.sv =====
// Datapath of the slot table: valid bits, signature memory, free-slot search,
// query scan pipeline and the output register. Depends on stq_pkg.
`default_nettype none

module stq_dp
    import stq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire t_func              i_func,
    input  wire logic [SLOT_W-1:0]  i_slot_index,
    input  wire logic [MASK_W-1:0]  i_mask_value,
    input  wire logic               i_m_tready,
    output t_dp_sts                 o_sts,
    output logic                    o_m_tvalid,
    output logic [SLOT_W-1:0]       o_result_index,
    output t_status                 o_status,
    output logic                    o_last
);

    // Slot state
    logic [MAX_SLOTS-1:0] r_valid;
    logic [SIG_W-1:0]     r_sig_mem [MAX_SLOTS];
    logic [SIG_W-1:0]     r_rdata;
    logic [SIG_W-1:0]     r_mask;

    // Scan pipeline: issue pointer, compare stage, held match
    logic [PTR_W-1:0]     r_ptr;
    logic                 r_s2_vld;
    logic [ADDR_W-1:0]    r_s2_idx;
    logic                 r_s2_slot_vld;
    logic                 r_pend_vld;
    logic [ADDR_W-1:0]    r_pend_idx;

    // Free-slot group summaries
    logic [NUM_GRP-1:0]   r_gfree;
    logic [GRP_IW-1:0]    r_gidx [NUM_GRP];
    logic [NUM_GRP-1:0]   n_gfree;
    logic [GRP_IW-1:0]    n_gidx [NUM_GRP];

    // Output register
    logic                 r_o_valid;
    logic [SLOT_W-1:0]    r_o_idx;
    t_status              r_o_status;
    logic                 r_o_last;

    logic                 out_free;
    logic                 in_range;
    logic                 s2_match;
    logic                 scan_adv;
    logic                 rd_en;
    logic                 pick_found;
    logic [ADDR_W-1:0]    pick_idx;
    logic                 push;
    logic [ADDR_W-1:0]    push_idx;
    t_status              push_status;
    logic                 push_last;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [SIG_W-1:0]     wr_data;

    assign out_free = !r_o_valid || i_m_tready;
    assign in_range = ({1'b0, i_slot_index} < (SLOT_W + 1)'(MAX_SLOTS));
    assign s2_match = r_s2_vld && r_s2_slot_vld && ((r_rdata & r_mask) == r_mask);
    // Hold the scan when a second match has nowhere to go
    assign scan_adv = (i_cmd == CMD_SCAN) && !(s2_match && r_pend_vld && !out_free);
    assign rd_en    = scan_adv && (r_ptr < PTR_W'(MAX_SLOTS));

    assign o_sts.out_free  = out_free;
    assign o_sts.scan_done = (r_ptr == PTR_W'(MAX_SLOTS)) && !r_s2_vld;

    // Lowest free slot inside each group
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_gfree[g] = 1'b0;
            n_gidx[g]  = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--) begin
                if ((g * GRP_SIZE + k) < MAX_SLOTS) begin
                    if (!r_valid[ADDR_W'(g * GRP_SIZE + k)]) begin
                        n_gfree[g] = 1'b1;
                        n_gidx[g]  = GRP_IW'(k);
                    end
                end
            end
        end
    end

    // Lowest group that has a free slot
    always_comb begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                pick_found = 1'b1;
                pick_idx   = ADDR_W'(g * GRP_SIZE + int'(r_gidx[g]));
            end
        end
    end

    always_comb begin
        push        = 1'b0;
        push_idx    = '0;
        push_status = ST_OK;
        push_last   = 1'b0;
        case (i_cmd)
            CMD_PICK: begin
                push      = 1'b1;
                push_last = 1'b1;
                if (pick_found) begin
                    push_idx = pick_idx;
                end else begin
                    push_status = ST_FULL;
                end
            end
            CMD_SCAN: begin
                if (scan_adv && s2_match && r_pend_vld) begin
                    push     = 1'b1;
                    push_idx = r_pend_idx;
                end
            end
            CMD_FINISH: begin
                push      = 1'b1;
                push_last = 1'b1;
                if (r_pend_vld) begin
                    push_idx = r_pend_idx;
                end else begin
                    push_status = ST_NOMATCH;
                end
            end
            default: push = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_slot_index[ADDR_W-1:0];
        wr_data = i_mask_value[SIG_W-1:0];
        if ((i_cmd == CMD_LOAD) && (i_func == FN_SET) && in_range) begin
            wr_en = 1'b1;
        end else if ((i_cmd == CMD_PICK) && pick_found) begin
            wr_en   = 1'b1;
            wr_addr = pick_idx;
            wr_data = '0;
        end
    end

    // Signature memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sig_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_sig_mem[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ptr      <= '0;
            r_s2_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if ((i_cmd == CMD_LOAD) && (i_func == FN_DESTROY) && in_range) begin
                r_valid[i_slot_index[ADDR_W-1:0]] <= 1'b0;
            end
            if ((i_cmd == CMD_PICK) && pick_found) begin
                r_valid[pick_idx] <= 1'b1;
            end

            if (i_cmd == CMD_LOAD) begin
                r_ptr      <= '0;
                r_s2_vld   <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (scan_adv) begin
                r_s2_vld <= rd_en;
                if (rd_en) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (s2_match) begin
                    r_pend_vld <= 1'b1;
                end
            end else if (i_cmd == CMD_FINISH) begin
                r_pend_vld <= 1'b0;
            end

            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_mask <= i_mask_value[SIG_W-1:0];
        end
        if (i_cmd == CMD_SUM) begin
            r_gfree <= n_gfree;
            for (int g = 0; g < NUM_GRP; g++) begin
                r_gidx[g] <= n_gidx[g];
            end
        end
        if (rd_en) begin
            r_s2_idx      <= r_ptr[ADDR_W-1:0];
            r_s2_slot_vld <= r_valid[r_ptr[ADDR_W-1:0]];
        end
        if (scan_adv && s2_match) begin
            r_pend_idx <= r_s2_idx;
        end
        if (push) begin
            r_o_idx    <= SLOT_W'(push_idx);
            r_o_status <= push_status;
            r_o_last   <= push_last;
        end
    end

    assign o_m_tvalid     = r_o_valid;
    assign o_result_index = r_o_idx;
    assign o_status       = r_o_status;
    assign o_last         = r_o_last;

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed over an untaken beat");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (push_status == ST_FULL)) |-> (&r_valid))
        else $error("table full reported with a free slot");

    a_create_takes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd == CMD_PICK) && pick_found) |-> !r_valid[pick_idx])
        else $error("create claimed a slot already in use");

    a_ptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(MAX_SLOTS))
        else $error("scan pointer ran past the table");

endmodule

`default_nettype wire

// ===== hw/rtl/slot_table_with_mask_query.sv =====
// Top level of the slot table with mask query: stream ports, field unpacking,
// sequencer stq_ctrl and datapath stq_dp. Depends on stq_pkg.
`default_nettype none

// The table holds MAX_SLOTS slots, each with a valid bit and a signature;
// all slots are free right after reset, with no clearing pass. One beat is
// taken at a time. Destroy and set signature are done as the beat is
// accepted. Create steps through accept, group summary of free slots and
// pick, and returns one beat; the pick step waits while the output register
// still holds an untaken beat. A query walks the signature memory one slot
// per cycle through its single read port, holding when a new match finds one
// already waiting and the output stalled; matches come out in ascending slot
// order, the final one flagged by tlast, or a single no-match beat when
// nothing qualifies.

module slot_table_with_mask_query
    import stq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // slot_index[5:0], mask_value[37:6]
    input  wire logic [FUNC_W-1:0]      i_s_tuser,   // func[1:0]
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // result_index[5:0]
    output logic [STATUS_W-1:0]         o_m_tuser,   // status[1:0]
    output logic                        o_m_tlast
);

    t_func             func;
    logic [SLOT_W-1:0] slot_index;
    logic [MASK_W-1:0] mask_value;
    t_cmd              cmd;
    t_dp_sts           dp_sts;
    logic [SLOT_W-1:0] result_index;
    t_status           status;

    assign func       = t_func'(i_s_tuser);
    assign slot_index = i_s_tdata[SLOT_W-1:0];
    assign mask_value = i_s_tdata[SLOT_W +: MASK_W];

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (func),
        .i_sts      (dp_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    stq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (func),
        .i_slot_index   (slot_index),
        .i_mask_value   (mask_value),
        .i_m_tready     (i_m_tready),
        .o_sts          (dp_sts),
        .o_m_tvalid     (o_m_tvalid),
        .o_result_index (result_index),
        .o_status       (status),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = OUT_TDATA_W'(result_index);
    assign o_m_tuser = status;

endmodule

`default_nettype wire
